// ===== rtl/core/rplc_pkg.sv =====
// shared types, codes and defaults for the rs485 packet link controller
package rplc_pkg;

  localparam int unsigned BufDepthDefault = 128;

  localparam int unsigned ReqW   = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned StatW  = 2;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 3;

  typedef enum logic [ReqW-1:0] {
    REQ_LOAD = 3'd0,
    REQ_TICK = 3'd1,
    REQ_RX   = 3'd2,
    REQ_IDLE = 3'd3,
    REQ_READ = 3'd4
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_DROP   = 2'd2
  } status_e;

  typedef enum logic {
    REG_RE_USED = 1'b0,
    REG_DE_USED = 1'b1
  } reg_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  typedef struct packed {
    logic re_used;
    logic de_used;
  } cfg_t;

endpackage

// ===== rtl/core/rs485_packet_link_controller_unit.sv =====
// top level of the rs485 half-duplex packet link controller
//
// channel   | direction | contents
// s_*       | in        | tdata {rx_index, data_byte}, tuser req_type, tlast last_byte
// m_*       | out       | tdata {status, read_data, packet_size, packet_done, de, re,
//           |           |        tx_data, tx_valid}
// apb       | in/out    | reg 0 re_drive_used at 0x0, reg 1 de_drive_used at 0x4
//
// for each item the accept edge reads the send or receive store, and the
// commit edge applies the update, writes the store and loads the output register
// the output register holds a result while the next item is accepted; a full
// output register stalls the update cycle until m_tready_i
// reset clears all counters and flags, the drives read low, both enables set
module rs485_packet_link_controller_unit #(
  parameter int unsigned BUF_DEPTH = rplc_pkg::BufDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  // [7:0] data_byte, [14:8] rx_index, [15] zero
  input  logic [rplc_pkg::InDataW-1:0]    s_tdata_i,
  // [2:0] req_type
  input  logic [rplc_pkg::ReqW-1:0]       s_tuser_i,
  input  logic                            s_tlast_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // [0] tx_valid, [8:1] tx_data, [9] re_drive, [10] de_drive, [11] packet_done,
  // [18:12] packet_size, [26:19] read_data, [28:27] status, [31:29] zero
  output logic [rplc_pkg::OutDataW-1:0]   m_tdata_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rplc_pkg::CfgAddrW-1:0]   paddr,
  input  logic [rplc_pkg::CfgDataW-1:0]   pwdata,
  output logic [rplc_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready
);

  localparam int unsigned PtrW = $clog2(BUF_DEPTH);
  localparam int unsigned CntW = $clog2(BUF_DEPTH + 1);
  localparam int unsigned CmpW = CntW + rplc_pkg::IdxW;
  localparam int unsigned ByteW = rplc_pkg::ByteW;
  localparam int unsigned SizeW = rplc_pkg::SizeW;

  rplc_pkg::cfg_t cfg;
  rplc_pkg::fsm_e state_q, state_d;

  logic                            accept;
  logic                            commit;

  logic [rplc_pkg::ReqW-1:0]       item_req_q;
  logic [ByteW-1:0]                item_data_q;
  logic                            item_last_q;
  logic                            item_idx_ok_q;
  logic                            idx_ok;

  logic [PtrW-1:0]                 load_cnt_q, load_cnt_d;
  logic [PtrW-1:0]                 remain_q, remain_d;
  logic [PtrW-1:0]                 send_pos_q, send_pos_d;
  logic                            tx_q, tx_d;
  logic [CntW-1:0]                 rx_cnt_q, rx_cnt_d;
  logic [SizeW-1:0]                pkt_size_q, pkt_size_d;

  logic                            send_we, rx_we;
  logic [ByteW-1:0]                send_rdata, rx_rdata;
  logic [PtrW-1:0]                 rx_raddr;

  logic                            o_tx_valid, o_done;
  logic [ByteW-1:0]                o_tx_data, o_rdata;
  rplc_pkg::status_e               o_status;

  logic                            m_valid_q, m_valid_d;
  logic [rplc_pkg::OutDataW-1:0]   m_data_q, m_data_d;

  rplc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign rx_raddr = PtrW'(s_tdata_i[14:8]);
  assign idx_ok   = CmpW'(s_tdata_i[14:8]) < CmpW'(BUF_DEPTH);

  rplc_ram #(.Depth(BUF_DEPTH), .Width(ByteW)) u_send_ram (
    .clk_i   (clk_i),
    .we_i    (send_we),
    .waddr_i (load_cnt_q),
    .wdata_i (item_data_q),
    .re_i    (accept),
    .raddr_i (send_pos_q),
    .rdata_o (send_rdata)
  );

  rplc_ram #(.Depth(BUF_DEPTH), .Width(ByteW)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_cnt_q[PtrW-1:0]),
    .wdata_i (item_data_q),
    .re_i    (accept),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  always_comb begin
    state_d    = state_q;
    s_tready_o = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      rplc_pkg::FSM_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          state_d = rplc_pkg::FSM_EXEC;
        end
      end
      rplc_pkg::FSM_EXEC: begin
        if (!m_valid_q || m_tready_i) begin
          commit  = 1'b1;
          state_d = rplc_pkg::FSM_IDLE;
        end
      end
      default: state_d = rplc_pkg::FSM_IDLE;
    endcase
  end

  assign accept = s_tvalid_i && s_tready_o;

  always_comb begin
    load_cnt_d = load_cnt_q;
    remain_d   = remain_q;
    send_pos_d = send_pos_q;
    tx_d       = tx_q;
    rx_cnt_d   = rx_cnt_q;
    pkt_size_d = pkt_size_q;
    send_we    = 1'b0;
    rx_we      = 1'b0;
    o_tx_valid = 1'b0;
    o_tx_data  = '0;
    o_done     = 1'b0;
    o_rdata    = '0;
    o_status   = rplc_pkg::ST_OK;
    case (item_req_q)
      rplc_pkg::REQ_LOAD: begin
        if (tx_q) begin
          o_status = rplc_pkg::ST_REJECT;
        end else if (load_cnt_q == PtrW'(BUF_DEPTH - 1)) begin
          o_status   = rplc_pkg::ST_REJECT;
          load_cnt_d = '0;
        end else begin
          send_we    = 1'b1;
          load_cnt_d = load_cnt_q + 1'b1;
          if (item_last_q) begin
            remain_d   = load_cnt_q + 1'b1;
            send_pos_d = '0;
            tx_d       = 1'b1;
            load_cnt_d = '0;
          end
        end
      end
      rplc_pkg::REQ_TICK: begin
        if (remain_q == '0) begin
          if (tx_q) begin
            tx_d       = 1'b0;
            send_pos_d = '0;
          end
        end else begin
          o_tx_valid = 1'b1;
          o_tx_data  = send_rdata;
          send_pos_d = send_pos_q + 1'b1;
          remain_d   = remain_q - 1'b1;
        end
      end
      rplc_pkg::REQ_RX: begin
        if (rx_cnt_q < CntW'(BUF_DEPTH)) begin
          rx_we    = 1'b1;
          rx_cnt_d = rx_cnt_q + 1'b1;
        end else begin
          o_status = rplc_pkg::ST_DROP;
        end
      end
      rplc_pkg::REQ_IDLE: begin
        if (rx_cnt_q != '0 && rx_cnt_q < CntW'(BUF_DEPTH)) begin
          pkt_size_d = SizeW'(rx_cnt_q);
        end else begin
          pkt_size_d = '0;
        end
        rx_cnt_d = '0;
        o_done   = 1'b1;
      end
      rplc_pkg::REQ_READ: begin
        if (item_idx_ok_q) begin
          o_rdata = rx_rdata;
        end
      end
      default: o_status = rplc_pkg::ST_OK;
    endcase
    if (!commit) begin
      send_we = 1'b0;
      rx_we   = 1'b0;
    end
  end

  always_comb begin
    m_data_d = m_data_q;
    if (commit) begin
      m_data_d = {3'b000, o_status, o_rdata, pkt_size_d, o_done,
                  tx_d && cfg.de_used, tx_d && cfg.re_used, o_tx_data, o_tx_valid};
    end
    m_valid_d = m_valid_q;
    if (commit) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rplc_pkg::FSM_IDLE;
      load_cnt_q <= '0;
      remain_q   <= '0;
      send_pos_q <= '0;
      tx_q       <= 1'b0;
      rx_cnt_q   <= '0;
      pkt_size_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      m_valid_q <= m_valid_d;
      if (commit) begin
        load_cnt_q <= load_cnt_d;
        remain_q   <= remain_d;
        send_pos_q <= send_pos_d;
        tx_q       <= tx_d;
        rx_cnt_q   <= rx_cnt_d;
        pkt_size_q <= pkt_size_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_req_q    <= s_tuser_i;
      item_data_q   <= s_tdata_i[7:0];
      item_last_q   <= s_tlast_i;
      item_idx_ok_q <= idx_ok;
    end
    m_data_q <= m_data_d;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

`ifndef NO_ASSERTIONS
  a_accept_enters_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == rplc_pkg::FSM_EXEC))
    else $error("accepted item did not enter the update cycle");

  a_idle_no_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tx_q |-> (remain_q == '0))
    else $error("bytes remaining while in receive direction");

  a_rx_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_cnt_q <= CntW'(BUF_DEPTH))
    else $error("receive count beyond store depth");

  a_stall_holds_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rplc_pkg::FSM_EXEC) && m_valid_q && !m_tready_i
      |=> (state_q == rplc_pkg::FSM_EXEC))
    else $error("update committed over an unread result");
`endif

endmodule

// ===== rtl/core/rplc_ram.sv =====
// single-port-write, single-port-read synchronous byte store
module rplc_ram #(
  parameter int unsigned Depth = rplc_pkg::BufDepthDefault,
  parameter int unsigned Width = rplc_pkg::ByteW,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rplc_apb_regs.sv =====
// apb configuration registers for drive enables
module rplc_apb_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rplc_pkg::CfgAddrW-1:0]    paddr,
  input  logic [rplc_pkg::CfgDataW-1:0]    pwdata,
  output logic [rplc_pkg::CfgDataW-1:0]    prdata,
  output logic                             pready,
  output rplc_pkg::cfg_t                   cfg_o
);

  rplc_pkg::cfg_t cfg_q;
  rplc_pkg::cfg_t cfg_d;
  logic           wr_en;
  rplc_pkg::reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = rplc_pkg::reg_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        rplc_pkg::REG_RE_USED: cfg_d.re_used = pwdata[0];
        rplc_pkg::REG_DE_USED: cfg_d.de_used = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      rplc_pkg::REG_RE_USED: prdata[0] = cfg_q.re_used;
      rplc_pkg::REG_DE_USED: prdata[0] = cfg_q.de_used;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{re_used: 1'b1, de_used: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
